// ----- rtl/dwvc_pkg.sv -----
// shared types, constants and register map of the dual wheel velocity controller
package dwvc_pkg;

    // lanes and field widths
    localparam int NUM_LANES   = 2;
    localparam int COUNT_W     = 16;
    localparam int DRIVE_W     = 14;
    localparam int TARGET_W    = 13;
    localparam int TC_W        = 12;
    localparam int GAIN_W      = 18;
    localparam int ERR_W       = 18;
    localparam int PHASE_W     = 7;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = GAIN_W + 1 + ERR_W;
    localparam int INC_W       = PROD_W + 1;
    localparam int PIPE_STAGES = 4;

    // defaults for the top level parameters
    localparam int DRIVE_LIMIT_DEF    = 7199;
    localparam int PROFILE_LENGTH_DEF = 80;

    // speed profile segment ends
    localparam int FWD_END  = 30;
    localparam int STOP_END = 40;
    localparam int REV_END  = 70;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_COUNTS    = 3'd0,
        REG_KP_FORWARD_LEFT  = 3'd1,
        REG_KP_REVERSE_LEFT  = 3'd2,
        REG_KD_LEFT          = 3'd3,
        REG_KP_FORWARD_RIGHT = 3'd4,
        REG_KP_REVERSE_RIGHT = 3'd5,
        REG_KD_RIGHT         = 3'd6
    } reg_idx_t;

    // register reset values
    localparam logic [TC_W-1:0]   TARGET_COUNTS_RST    = 12'd280;
    localparam logic [GAIN_W-1:0] KP_FORWARD_LEFT_RST  = 18'd65536;
    localparam logic [GAIN_W-1:0] KP_REVERSE_LEFT_RST  = 18'd78643;
    localparam logic [GAIN_W-1:0] KD_LEFT_RST          = 18'd197;
    localparam logic [GAIN_W-1:0] KP_FORWARD_RIGHT_RST = 18'd75366;
    localparam logic [GAIN_W-1:0] KP_REVERSE_RIGHT_RST = 18'd77332;
    localparam logic [GAIN_W-1:0] KD_RIGHT_RST         = 18'd151;

    // lane index 0 is the left wheel, 1 the right wheel
    typedef struct packed {
        logic [TC_W-1:0]                  target_counts;
        logic [NUM_LANES-1:0][GAIN_W-1:0] kp_fwd;
        logic [NUM_LANES-1:0][GAIN_W-1:0] kp_rev;
        logic [NUM_LANES-1:0][GAIN_W-1:0] kd;
    } cfg_t;

    // pipeline control shared by both lanes
    typedef struct packed {
        logic adv;     // whole pipeline moves one stage
        logic accept;  // input transfer this cycle
        logic rev;     // target of the item entering is negative
        logic commit;  // item in the last arithmetic stage updates the drive
    } lane_ctrl_t;

endpackage

// ----- rtl/dual_wheel_velocity_controller_unit.sv -----
// top level of the dual wheel incremental pid velocity controller
// Each input transfer is one control tick carrying the left and right encoder counts.
// The block steps a built-in speed profile (forward, stop, reverse, stop over
// PROFILE_LENGTH ticks), forms one common target, and updates the drive of each wheel
// incrementally with Q16 proportional and derivative gains, truncating toward zero and
// saturating to +-DRIVE_LIMIT. Both wheels are computed in two identical lanes side by
// side and merged into one result transfer holding both drives and the target used.
// A new tick is taken every cycle unless a result waits untaken; each tick passes through
// the four pipeline registers: error, gain products, increment add, and the drive
// accumulate/saturate register which is also the output register. Back pressure on
// the result side holds the whole pipeline. Gains and target are set over the
// APB-style port at byte address 4*i in register order and should be written
// while no tick is in flight.
module dual_wheel_velocity_controller_unit #(
    parameter int DRIVE_LIMIT    = dwvc_pkg::DRIVE_LIMIT_DEF,
    parameter int PROFILE_LENGTH = dwvc_pkg::PROFILE_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // apb-style configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dwvc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dwvc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [dwvc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // encoder counts in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dwvc_pkg::COUNT_W-1:0]   s_left_count,
    input  logic signed [dwvc_pkg::COUNT_W-1:0]   s_right_count,
    // drives out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dwvc_pkg::DRIVE_W-1:0]   m_drive_left,
    output logic signed [dwvc_pkg::DRIVE_W-1:0]   m_drive_right,
    output logic signed [dwvc_pkg::TARGET_W-1:0]  m_target_now
);

    localparam int ACC_W = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam int PS    = dwvc_pkg::PIPE_STAGES;

    dwvc_pkg::cfg_t                        cfg;
    dwvc_pkg::lane_ctrl_t                  ctrl;
    logic                                  adv;
    logic                                  accept;
    logic signed [dwvc_pkg::TARGET_W-1:0]  target_c;
    logic [PS:1]                           vld_reg;
    logic signed [dwvc_pkg::TARGET_W-1:0]  tgt_reg [1:PS];
    logic signed [dwvc_pkg::COUNT_W-1:0]   lane_count [dwvc_pkg::NUM_LANES];
    logic signed [ACC_W-1:0]               lane_drive [dwvc_pkg::NUM_LANES];

    // configuration registers
    dwvc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow: everything moves unless a result is waiting and not taken
    assign adv     = !vld_reg[PS] || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // speed profile
    dwvc_profile #(
        .PROFILE_LENGTH (PROFILE_LENGTH)
    ) u_profile (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .target_counts (cfg.target_counts),
        .target        (target_c)
    );

    always_comb begin
        ctrl.adv    = adv;
        ctrl.accept = accept;
        ctrl.rev    = target_c < 0;
        ctrl.commit = adv && vld_reg[PS-1];
    end

    // wheel lanes
    assign lane_count[0] = s_left_count;
    assign lane_count[1] = s_right_count;

    for (genvar g = 0; g < dwvc_pkg::NUM_LANES; g++) begin : g_lane
        dwvc_lane #(
            .DRIVE_LIMIT (DRIVE_LIMIT)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .target  (target_c),
            .count   (lane_count[g]),
            .kp_fwd  (cfg.kp_fwd[g]),
            .kp_rev  (cfg.kp_rev[g]),
            .kd      (cfg.kd[g]),
            .drive   (lane_drive[g])
        );
    end

    // valid and target travel alongside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PS-1:1], accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tgt_reg[1] <= target_c;
            for (int k = 2; k <= PS; k++) begin
                tgt_reg[k] <= tgt_reg[k-1];
            end
        end
    end

    // merge lanes into one result transfer
    assign m_valid       = vld_reg[PS];
    assign m_drive_left  = dwvc_pkg::DRIVE_W'(lane_drive[0]);
    assign m_drive_right = dwvc_pkg::DRIVE_W'(lane_drive[1]);
    assign m_target_now  = tgt_reg[PS];

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> vld_reg[1])
        else $error("accepted transfer did not enter the pipeline");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_valid)
        else $error("drive update without a result");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg) && $stable(lane_drive[0])
            && $stable(lane_drive[1]))
        else $error("pipeline moved while the result was stalled");

endmodule

// ----- rtl/dwvc_regs.sv -----
// configuration register file behind the apb-style port
module dwvc_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dwvc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dwvc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dwvc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output dwvc_pkg::cfg_t                   cfg
);

    dwvc_pkg::cfg_t      cfg_reg;
    dwvc_pkg::cfg_t      cfg_next;
    dwvc_pkg::reg_idx_t  idx;
    logic                wr_en;

    assign idx    = dwvc_pkg::reg_idx_t'(paddr[dwvc_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                dwvc_pkg::REG_TARGET_COUNTS:
                    cfg_next.target_counts = pwdata[dwvc_pkg::TC_W-1:0];
                dwvc_pkg::REG_KP_FORWARD_LEFT:
                    cfg_next.kp_fwd[0] = pwdata[dwvc_pkg::GAIN_W-1:0];
                dwvc_pkg::REG_KP_REVERSE_LEFT:
                    cfg_next.kp_rev[0] = pwdata[dwvc_pkg::GAIN_W-1:0];
                dwvc_pkg::REG_KD_LEFT:
                    cfg_next.kd[0] = pwdata[dwvc_pkg::GAIN_W-1:0];
                dwvc_pkg::REG_KP_FORWARD_RIGHT:
                    cfg_next.kp_fwd[1] = pwdata[dwvc_pkg::GAIN_W-1:0];
                dwvc_pkg::REG_KP_REVERSE_RIGHT:
                    cfg_next.kp_rev[1] = pwdata[dwvc_pkg::GAIN_W-1:0];
                dwvc_pkg::REG_KD_RIGHT:
                    cfg_next.kd[1] = pwdata[dwvc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_counts <= dwvc_pkg::TARGET_COUNTS_RST;
            cfg_reg.kp_fwd[0]     <= dwvc_pkg::KP_FORWARD_LEFT_RST;
            cfg_reg.kp_rev[0]     <= dwvc_pkg::KP_REVERSE_LEFT_RST;
            cfg_reg.kd[0]         <= dwvc_pkg::KD_LEFT_RST;
            cfg_reg.kp_fwd[1]     <= dwvc_pkg::KP_FORWARD_RIGHT_RST;
            cfg_reg.kp_rev[1]     <= dwvc_pkg::KP_REVERSE_RIGHT_RST;
            cfg_reg.kd[1]         <= dwvc_pkg::KD_RIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            dwvc_pkg::REG_TARGET_COUNTS:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.target_counts);
            dwvc_pkg::REG_KP_FORWARD_LEFT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kp_fwd[0]);
            dwvc_pkg::REG_KP_REVERSE_LEFT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kp_rev[0]);
            dwvc_pkg::REG_KD_LEFT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kd[0]);
            dwvc_pkg::REG_KP_FORWARD_RIGHT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kp_fwd[1]);
            dwvc_pkg::REG_KP_REVERSE_RIGHT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kp_rev[1]);
            dwvc_pkg::REG_KD_RIGHT:
                prdata = dwvc_pkg::APB_DATA_W'(cfg_reg.kd[1]);
            default: prdata = '0;
        endcase
    end

endmodule

// ----- rtl/dwvc_profile.sv -----
// speed profile phase counter and common target generator
module dwvc_profile #(
    parameter int PROFILE_LENGTH = dwvc_pkg::PROFILE_LENGTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [dwvc_pkg::TC_W-1:0]           target_counts,
    output logic signed [dwvc_pkg::TARGET_W-1:0] target
);

    localparam logic [dwvc_pkg::PHASE_W-1:0] LAST_PHASE =
        dwvc_pkg::PHASE_W'(PROFILE_LENGTH - 1);
    localparam logic [dwvc_pkg::PHASE_W-1:0] PH_FWD_END  =
        dwvc_pkg::PHASE_W'(dwvc_pkg::FWD_END);
    localparam logic [dwvc_pkg::PHASE_W-1:0] PH_STOP_END =
        dwvc_pkg::PHASE_W'(dwvc_pkg::STOP_END);
    localparam logic [dwvc_pkg::PHASE_W-1:0] PH_REV_END  =
        dwvc_pkg::PHASE_W'(dwvc_pkg::REV_END);

    logic [dwvc_pkg::PHASE_W-1:0]         phase_reg;
    logic [dwvc_pkg::PHASE_W-1:0]         phase_next;
    logic signed [dwvc_pkg::TARGET_W-1:0] tc_pos;

    // phase advances on every transfer and wraps at the profile length
    always_comb begin
        phase_next = (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    // target for the phase the item lands in
    assign tc_pos = $signed({1'b0, target_counts});

    always_comb begin
        priority if (phase_next < PH_FWD_END) begin
            target = tc_pos;
        end else if (phase_next < PH_STOP_END) begin
            target = '0;
        end else if (phase_next < PH_REV_END) begin
            target = -tc_pos;
        end else begin
            target = '0;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= LAST_PHASE)
        else $error("profile phase beyond profile length");

    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(phase_reg))
        else $error("profile phase moved without a transfer");

endmodule

// ----- rtl/dwvc_lane.sv -----
// one wheel lane: error, gain products, increment sum, truncate and saturate
module dwvc_lane #(
    parameter int DRIVE_LIMIT = dwvc_pkg::DRIVE_LIMIT_DEF,
    localparam int ACC_W = $clog2(DRIVE_LIMIT + 1) + 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dwvc_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [dwvc_pkg::TARGET_W-1:0]  target,
    input  logic signed [dwvc_pkg::COUNT_W-1:0]   count,
    input  logic [dwvc_pkg::GAIN_W-1:0]           kp_fwd,
    input  logic [dwvc_pkg::GAIN_W-1:0]           kp_rev,
    input  logic [dwvc_pkg::GAIN_W-1:0]           kd,
    output logic signed [ACC_W-1:0]               drive
);

    localparam int WHOLE_W = dwvc_pkg::INC_W - dwvc_pkg::FRAC_W;
    localparam int Q_W     = WHOLE_W + 2;
    localparam logic signed [Q_W-1:0]   LIM_Q = Q_W'(DRIVE_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_A = ACC_W'(DRIVE_LIMIT);

    logic signed [dwvc_pkg::ERR_W-1:0]  err_c;
    logic signed [dwvc_pkg::ERR_W-1:0]  derr_c;
    logic signed [dwvc_pkg::ERR_W-1:0]  last_err_reg;
    logic signed [dwvc_pkg::ERR_W-1:0]  err_s1_reg;
    logic signed [dwvc_pkg::ERR_W-1:0]  derr_s1_reg;
    logic                               rev_s1_reg;
    logic [dwvc_pkg::GAIN_W-1:0]        kp_sel;
    logic signed [dwvc_pkg::PROD_W-1:0] pp_c;
    logic signed [dwvc_pkg::PROD_W-1:0] pd_c;
    logic signed [dwvc_pkg::PROD_W-1:0] pp_s2_reg;
    logic signed [dwvc_pkg::PROD_W-1:0] pd_s2_reg;
    logic signed [dwvc_pkg::INC_W-1:0]  inc_s3_reg;
    logic signed [WHOLE_W-1:0]          whole_c;
    logic signed [Q_W-1:0]              q_floor_c;
    logic                               frac_nz;
    logic                               round_up;
    logic signed [Q_W-1:0]              q_c;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;

    // stage 0: error against target and its change since the last tick
    assign err_c  = dwvc_pkg::ERR_W'(target) - dwvc_pkg::ERR_W'(count);
    assign derr_c = err_c - last_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (ctrl.accept) begin
            last_err_reg <= err_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            err_s1_reg  <= err_c;
            derr_s1_reg <= derr_c;
            rev_s1_reg  <= ctrl.rev;
        end
    end

    // stage 1: proportional and derivative products
    assign kp_sel = rev_s1_reg ? kp_rev : kp_fwd;
    assign pp_c   = $signed({1'b0, kp_sel}) * err_s1_reg;
    assign pd_c   = $signed({1'b0, kd}) * derr_s1_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            pp_s2_reg <= pp_c;
            pd_s2_reg <= pd_c;
        end
    end

    // stage 2: q16 increment
    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            inc_s3_reg <= dwvc_pkg::INC_W'(pp_s2_reg) + dwvc_pkg::INC_W'(pd_s2_reg);
        end
    end

    // stage 3: add to drive, truncate toward zero, saturate
    // the old drive has no fraction, so the floor of the new sum is the drive plus the
    // floored increment; a negative sum with a fraction left moves up by one
    assign whole_c   = inc_s3_reg[dwvc_pkg::INC_W-1:dwvc_pkg::FRAC_W];
    assign frac_nz   = |inc_s3_reg[dwvc_pkg::FRAC_W-1:0];
    assign q_floor_c = Q_W'(acc_reg) + Q_W'(whole_c);
    assign round_up  = q_floor_c[Q_W-1] && frac_nz;

    always_comb begin
        q_c = q_floor_c + {{(Q_W-1){1'b0}}, round_up};
        if (q_c > LIM_Q) begin
            acc_next = LIM_A;
        end else if (q_c < -LIM_Q) begin
            acc_next = -LIM_A;
        end else begin
            acc_next = q_c[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.commit) begin
            acc_reg <= acc_next;
        end
    end

    assign drive = acc_reg;

    a_drive_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg <= LIM_A) && (acc_reg >= -LIM_A))
        else $error("lane drive outside the saturation limit");

endmodule

// ----- tb/sv/dwvc_drive_monitor.sv -----
// watches the tick and drive channels, predicts each drive result and compares it
`timescale 1ns / 1ps

module dwvc_drive_monitor #(
    parameter int DRIVE_LIMIT    = dwvc_pkg::DRIVE_LIMIT_DEF,
    parameter int PROFILE_LENGTH = dwvc_pkg::PROFILE_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [dwvc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dwvc_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [dwvc_pkg::COUNT_W-1:0]   s_left_count,
    input  logic signed [dwvc_pkg::COUNT_W-1:0]   s_right_count,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [dwvc_pkg::DRIVE_W-1:0]   m_drive_left,
    input  logic signed [dwvc_pkg::DRIVE_W-1:0]   m_drive_right,
    input  logic signed [dwvc_pkg::TARGET_W-1:0]  m_target_now,
    output int                                    fail_count,
    output int                                    pending_count,
    output int                                    checked_count,
    output int                                    clipped_count
);
    import dwvc_pkg::*;

    typedef struct packed {
        logic [DRIVE_W-1:0]  left;
        logic [DRIVE_W-1:0]  right;
        logic [TARGET_W-1:0] target;
    } drive_result_t;

    // register copy, lane 0 is left and lane 1 is right
    logic [TC_W-1:0]   target_counts;
    logic [GAIN_W-1:0] kp_fwd [NUM_LANES];
    logic [GAIN_W-1:0] kp_rev [NUM_LANES];
    logic [GAIN_W-1:0] kd     [NUM_LANES];

    // controller state
    int phase;
    int drive_acc [NUM_LANES];
    int last_err  [NUM_LANES];

    drive_result_t pending_drives[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        clipped_count = 0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, checked_count);
        fail_count++;
    endtask

    // incremental pid update: exact q16 sum, truncate toward zero, saturate
    function automatic int next_drive(int acc, int prev_err, int err, longint kp, longint kd_g);
        longint one;
        longint sum;
        longint q;
        one = longint'(1) << FRAC_W;
        sum = longint'(acc) * one + kp * err + kd_g * (err - prev_err);
        q = sum / one;
        if (q > DRIVE_LIMIT)
            q = DRIVE_LIMIT;
        else if (q < -DRIVE_LIMIT)
            q = -DRIVE_LIMIT;
        return int'(q);
    endfunction

    always @(posedge aclk) begin
        drive_result_t want;
        drive_result_t got;
        int target;
        int cnt;
        int err;
        logic rev;
        if (!aresetn) begin
            target_counts = TARGET_COUNTS_RST;
            kp_fwd[0]     = KP_FORWARD_LEFT_RST;
            kp_rev[0]     = KP_REVERSE_LEFT_RST;
            kd[0]         = KD_LEFT_RST;
            kp_fwd[1]     = KP_FORWARD_RIGHT_RST;
            kp_rev[1]     = KP_REVERSE_RIGHT_RST;
            kd[1]         = KD_RIGHT_RST;
            phase         = 0;
            for (int i = 0; i < NUM_LANES; i++) begin
                drive_acc[i] = 0;
                last_err[i]  = 0;
            end
            pending_drives.delete();
            pending_count = 0;
        end else begin
            // register writes, only the register width is kept
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_TARGET_COUNTS:    target_counts = pwdata[TC_W-1:0];
                    REG_KP_FORWARD_LEFT:  kp_fwd[0] = pwdata[GAIN_W-1:0];
                    REG_KP_REVERSE_LEFT:  kp_rev[0] = pwdata[GAIN_W-1:0];
                    REG_KD_LEFT:          kd[0] = pwdata[GAIN_W-1:0];
                    REG_KP_FORWARD_RIGHT: kp_fwd[1] = pwdata[GAIN_W-1:0];
                    REG_KP_REVERSE_RIGHT: kp_rev[1] = pwdata[GAIN_W-1:0];
                    REG_KD_RIGHT:         kd[1] = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // tick transfer: step the profile and both wheels
            if (s_valid && s_ready) begin
                phase = phase + 1;
                if (phase >= PROFILE_LENGTH)
                    phase = 0;
                if (phase < FWD_END)
                    target = target_counts;
                else if (phase < STOP_END)
                    target = 0;
                else if (phase < REV_END)
                    target = -int'(target_counts);
                else
                    target = 0;
                rev = (target < 0);
                for (int i = 0; i < NUM_LANES; i++) begin
                    cnt = (i == 0) ? int'(s_left_count) : int'(s_right_count);
                    err = target - cnt;
                    drive_acc[i] = next_drive(drive_acc[i], last_err[i], err,
                                              rev ? kp_rev[i] : kp_fwd[i], kd[i]);
                    last_err[i] = err;
                end
                want.left   = DRIVE_W'(drive_acc[0]);
                want.right  = DRIVE_W'(drive_acc[1]);
                want.target = TARGET_W'(target);
                pending_drives.push_back(want);
            end

            // drive transfer: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_drives.size() == 0) begin
                    note_mismatch("unexpected result", int'(m_drive_left), 0);
                end else begin
                    want = pending_drives.pop_front();
                    got.left   = m_drive_left;
                    got.right  = m_drive_right;
                    got.target = m_target_now;
                    if (got.left !== want.left)
                        note_mismatch("drive_left", int'($signed(got.left)),
                                      int'($signed(want.left)));
                    if (got.right !== want.right)
                        note_mismatch("drive_right", int'($signed(got.right)),
                                      int'($signed(want.right)));
                    if (got.target !== want.target)
                        note_mismatch("target_now", int'($signed(got.target)),
                                      int'($signed(want.target)));
                    if ($signed(want.left) == DRIVE_LIMIT || $signed(want.left) == -DRIVE_LIMIT
                        || $signed(want.right) == DRIVE_LIMIT
                        || $signed(want.right) == -DRIVE_LIMIT)
                        clipped_count++;
                    checked_count++;
                end
            end
            pending_count = pending_drives.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// top of the velocity controller testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import dwvc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 225;
    localparam int GAIN_MAX      = (1 << GAIN_W) - 1;
    localparam int TC_MAX        = (1 << TC_W) - 1;
    localparam logic [REG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

    // gain setting styles for the random phases
    localparam int STYLE_NOMINAL = 0;
    localparam int STYLE_FULL    = 1;
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_GENTLE  = 3;

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [COUNT_W-1:0]    s_left_count;
    logic signed [COUNT_W-1:0]    s_right_count;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [DRIVE_W-1:0]    m_drive_left;
    logic signed [DRIVE_W-1:0]    m_drive_right;
    logic signed [TARGET_W-1:0]   m_target_now;

    int fail_count;
    int pending_count;
    int checked_count;
    int clipped_count;
    int cycle_count;
    int send_calm;
    int take_calm;
    int tc_now;
    int settings_count;

    dual_wheel_velocity_controller_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_left  (m_drive_left),
        .m_drive_right (m_drive_right),
        .m_target_now  (m_target_now)
    );

    dwvc_drive_monitor monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_left  (m_drive_left),
        .m_drive_right (m_drive_right),
        .m_target_now  (m_target_now),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .clipped_count (clipped_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run length guard
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_count);
            $display("tb failed");
            $finish;
        end
    end

    // wait cycles before a transfer, with occasional runs of back to back transfers
    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic bus_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register write, sometimes with junk above the register width
    task automatic set_reg(input reg_idx_t idx, input int unsigned value, input int width);
        logic [APB_DATA_W-1:0] data;
        data = APB_DATA_W'(value) & ((APB_DATA_W'(1) << width) - 1);
        if ($urandom_range(0, 1) == 1)
            data = data | ($urandom() << width);
        bus_write({idx, 2'b00}, data);
    endtask

    task automatic program_regs(input int tc, input int kpfl, input int kprl, input int kdl,
                                input int kpfr, input int kprr, input int kdr);
        set_reg(REG_TARGET_COUNTS, tc, TC_W);
        set_reg(REG_KP_FORWARD_LEFT, kpfl, GAIN_W);
        set_reg(REG_KP_REVERSE_LEFT, kprl, GAIN_W);
        set_reg(REG_KD_LEFT, kdl, GAIN_W);
        set_reg(REG_KP_FORWARD_RIGHT, kpfr, GAIN_W);
        set_reg(REG_KP_REVERSE_RIGHT, kprr, GAIN_W);
        set_reg(REG_KD_RIGHT, kdr, GAIN_W);
        tc_now = tc;
        settings_count++;
    endtask

    task automatic send_tick(input int left, input int right);
        int gap;
        gap = draw_pause(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_left_count  <= COUNT_W'(left);
        s_right_count <= COUNT_W'(right);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // let every tick come out before touching the registers
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (2 * PIPE_STAGES) @(negedge aclk);
    endtask

    function automatic int draw_gain(input int style, input bit is_kd);
        case (style)
            STYLE_NOMINAL: return is_kd ? $urandom_range(0, 1500) : $urandom_range(40000, 100000);
            STYLE_FULL:    return $urandom_range(0, GAIN_MAX);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 2))
                    0:       return 0;
                    1:       return GAIN_MAX;
                    default: return $urandom_range(0, GAIN_MAX);
                endcase
            end
            default:       return is_kd ? $urandom_range(0, 300) : $urandom_range(0, 8000);
        endcase
    endfunction

    // encoder counts: mostly close to one of the profile targets, some wild
    function automatic int draw_count();
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                case ($urandom_range(0, 2))
                    0:       base = tc_now;
                    1:       base = 0;
                    default: base = -tc_now;
                endcase
                return base + $urandom_range(0, 128) - 64;
            end
            5, 6, 7: return int'($signed(COUNT_W'($urandom())));
            8:       return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 16) - 8;
        endcase
    endfunction

    // result side: random stalls plus one long hold-off to back up the pipeline
    initial begin
        int pause;
        int taken;
        m_ready   = 1'b0;
        take_calm = 0;
        taken     = 0;
        wait (aresetn === 1'b1);
        forever begin
            pause = draw_pause(take_calm);
            if (taken == HOLD_AT)
                pause = HOLD_CYCLES;
            @(negedge aclk);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // stimulus
    initial begin
        int style;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_left_count   = '0;
        s_right_count  = '0;
        send_calm      = 0;
        tc_now         = TARGET_COUNTS_RST;
        settings_count = 1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset gains: count extremes and exact target
        send_tick(0, 0);
        send_tick(32767, 32767);
        send_tick(-32768, -32768);
        send_tick(32767, -32768);
        send_tick(-32768, 32767);
        send_tick(-1, 1);
        send_tick(280, 280);
        send_tick(280, -280);
        drain();

        // largest gains and target drive the output into the limits
        program_regs(TC_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        // a write to an unmapped index must change nothing
        bus_write({UNUSED_REG_IDX, 2'b00}, $urandom());
        send_tick(-32768, 32767);
        send_tick(32767, -32768);
        send_tick(0, 0);
        send_tick(4095, -4095);
        send_tick(-1, -1);
        send_tick(12345, -12345);
        drain();

        // zero gains: drives hold, target zero
        program_regs(0, 0, 0, 0, 0, 0, 0);
        send_tick(100, -100);
        send_tick(32767, -32768);
        send_tick(0, 0);
        drain();

        // random phases through every gain style
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            style = p % 4;
            program_regs(style == STYLE_EXTREME ? ($urandom_range(0, 1) ? TC_MAX : 0) :
                         style == STYLE_NOMINAL ? $urandom_range(50, 800) :
                         $urandom_range(0, TC_MAX),
                         draw_gain(style, 0), draw_gain(style, 0), draw_gain(style, 1),
                         draw_gain(style, 0), draw_gain(style, 0), draw_gain(style, 1));
            for (int i = 0; i < PHASE_TICKS; i++)
                send_tick(draw_count(), draw_count());
            drain();
        end

        $display("checked %0d ticks under %0d register settings, %0d with a drive at the limit",
                 checked_count, settings_count, clipped_count);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dwvc_pkg.sv
rtl/dwvc_regs.sv
rtl/dwvc_profile.sv
rtl/dwvc_lane.sv
rtl/dual_wheel_velocity_controller_unit.sv
tb/sv/dwvc_drive_monitor.sv
tb/sv/tb.sv
